[hw/rtl/lgss_pkg.sv]
package lgss_pkg;

   localparam int SLOT_CAPACITY = 8;
   localparam int ADAPTER_BITS  = 8;
   localparam int ID_W          = $clog2(SLOT_CAPACITY);
   localparam int CNT_W         = $clog2(SLOT_CAPACITY + 1);
   localparam int CFG_W         = 4;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;

   localparam logic [OP_W-1:0] OP_ADMIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_RETIRE = 2'd1;
   localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic finish;
   } lgss_cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_last;
   } lgss_status_type;

endpackage

[hw/rtl/largest_group_slot_scheduler.sv]
// Slot table with a largest-adapter-group pick. One item is worked on at a
// time: admit, retire and unused opcodes go from acceptance to a finish
// state that writes the result register, and the next item can be taken
// once that is done; pick scans the active slots one per cycle through a
// shared count-and-compare unit before its finish state. A finished result
// waits in the output register while the next item is accepted; the table
// is only updated once that register is free. Writing the slot limit
// empties the table and reloads the free id stack.
module largest_group_slot_scheduler
   import lgss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [ADAPTER_BITS-1:0]  req_adapter,
   input  logic [ID_W-1:0]          req_retire_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_slot_id,
   output logic [ADAPTER_BITS-1:0]  rsp_group_adapter,
   output logic [CNT_W-1:0]         rsp_group_size,
   output logic [SLOT_CAPACITY-1:0] rsp_group_members,
   input  logic                     csr_write_enable,
   input  logic [CFG_W-1:0]         csr_write_data
);

   lgss_cmd_type    cmd;
   lgss_status_type status;

   lgss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   lgss_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_adapter       (req_adapter),
      .req_retire_id     (req_retire_id),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_status        (rsp_status),
      .rsp_slot_id       (rsp_slot_id),
      .rsp_group_adapter (rsp_group_adapter),
      .rsp_group_size    (rsp_group_size),
      .rsp_group_members (rsp_group_members)
   );

endmodule

[hw/rtl/lgss_ctrl.sv]
module lgss_ctrl
   import lgss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lgss_status_type       status,
   output lgss_cmd_type          cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_opcode == OP_PICK) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (status.empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            // result register must be free before the table is updated
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/lgss_datapath.sv]
module lgss_datapath
   import lgss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lgss_cmd_type             cmd,
   output lgss_status_type          status,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [ADAPTER_BITS-1:0]  req_adapter,
   input  logic [ID_W-1:0]          req_retire_id,
   input  logic                     csr_write_enable,
   input  logic [CFG_W-1:0]         csr_write_data,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_slot_id,
   output logic [ADAPTER_BITS-1:0]  rsp_group_adapter,
   output logic [CNT_W-1:0]         rsp_group_size,
   output logic [SLOT_CAPACITY-1:0] rsp_group_members
);

   // slot table in admit order, entries at or above active_count are stale
   logic [ADAPTER_BITS-1:0] order_adapter_ff [SLOT_CAPACITY];
   logic [ADAPTER_BITS-1:0] order_adapter_in [SLOT_CAPACITY];
   logic [ID_W-1:0]         order_id_ff      [SLOT_CAPACITY];
   logic [ID_W-1:0]         order_id_in      [SLOT_CAPACITY];
   logic [ID_W-1:0]         free_stack_ff    [SLOT_CAPACITY];
   logic [ID_W-1:0]         free_stack_in    [SLOT_CAPACITY];
   logic [CNT_W-1:0]        active_count_ff, active_count_in;
   logic [CNT_W-1:0]        free_count_ff, free_count_in;
   logic [CNT_W-1:0]        slot_limit_ff, slot_limit_in;

   logic [OP_W-1:0]         op_ff, op_in;
   logic [ADAPTER_BITS-1:0] adapter_ff, adapter_in;
   logic [ID_W-1:0]         rid_ff, rid_in;

   logic [ID_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]        best_size_ff, best_size_in;
   logic [ADAPTER_BITS-1:0] best_adapter_ff, best_adapter_in;

   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]          rsp_slot_id_ff, rsp_slot_id_in;
   logic [ADAPTER_BITS-1:0]  rsp_group_adapter_ff, rsp_group_adapter_in;
   logic [CNT_W-1:0]         rsp_group_size_ff, rsp_group_size_in;
   logic [SLOT_CAPACITY-1:0] rsp_group_members_ff, rsp_group_members_in;

   logic [SLOT_CAPACITY-1:0] live;
   logic [SLOT_CAPACITY-1:0] id_hit;
   logic [SLOT_CAPACITY-1:0] shift_pos;
   logic [SLOT_CAPACITY-1:0] same_cur;
   logic [SLOT_CAPACITY-1:0] same_best;
   logic [CNT_W-1:0]         cur_count;
   logic [CNT_W-1:0]         free_top;
   logic [CNT_W-1:0]         reload_n;
   logic [CFG_W-1:0]         cfg_clamped;
   logic                     admit_full;
   logic                     retire_found;

   assign free_top = free_count_ff - CNT_W'(1);

   always_comb begin
      if (csr_write_data == '0) begin
         cfg_clamped = CFG_W'(1);
      end else if (csr_write_data > CFG_W'(SLOT_CAPACITY)) begin
         cfg_clamped = CFG_W'(SLOT_CAPACITY);
      end else begin
         cfg_clamped = csr_write_data;
      end
   end
   assign reload_n = CNT_W'(cfg_clamped);

   // per-entry compares, all in parallel
   always_comb begin
      logic seen;
      seen      = 1'b0;
      cur_count = '0;
      for (int i = 0; i < SLOT_CAPACITY; i++) begin
         live[i]      = CNT_W'(i) < active_count_ff;
         id_hit[i]    = live[i] && (order_id_ff[i] == rid_ff);
         seen         = seen | id_hit[i];
         shift_pos[i] = seen;
         same_cur[i]  = live[i] && (order_adapter_ff[i] == order_adapter_ff[scan_idx_ff]);
         same_best[i] = live[i] && (order_adapter_ff[i] == best_adapter_ff);
         cur_count    = cur_count + CNT_W'(same_cur[i]);
      end
      retire_found = seen;
   end

   assign admit_full = (active_count_ff >= slot_limit_ff) || (free_count_ff == '0) ||
                       (active_count_ff >= CNT_W'(SLOT_CAPACITY));

   assign status.empty     = (active_count_ff == '0);
   assign status.scan_last = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == active_count_ff;

   always_comb begin
      order_adapter_in     = order_adapter_ff;
      order_id_in          = order_id_ff;
      free_stack_in        = free_stack_ff;
      active_count_in      = active_count_ff;
      free_count_in        = free_count_ff;
      slot_limit_in        = slot_limit_ff;
      op_in                = op_ff;
      adapter_in           = adapter_ff;
      rid_in               = rid_ff;
      scan_idx_in          = scan_idx_ff;
      best_size_in         = best_size_ff;
      best_adapter_in      = best_adapter_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_slot_id_in       = rsp_slot_id_ff;
      rsp_group_adapter_in = rsp_group_adapter_ff;
      rsp_group_size_in    = rsp_group_size_ff;
      rsp_group_members_in = rsp_group_members_ff;

      if (cmd.capture) begin
         op_in           = req_opcode;
         adapter_in      = req_adapter;
         rid_in          = req_retire_id;
         scan_idx_in     = '0;
         best_size_in    = '0;
         best_adapter_in = '0;
      end

      // strict greater keeps the earliest admitted adapter on a tie
      if (cmd.scan_step) begin
         if (cur_count > best_size_ff) begin
            best_size_in    = cur_count;
            best_adapter_in = order_adapter_ff[scan_idx_ff];
         end
         scan_idx_in = scan_idx_ff + ID_W'(1);
      end

      if (cmd.finish) begin
         rsp_status_in        = ST_OK;
         rsp_slot_id_in       = '0;
         rsp_group_adapter_in = '0;
         rsp_group_size_in    = '0;
         rsp_group_members_in = '0;
         case (op_ff)
            OP_ADMIT: begin
               if (admit_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  free_count_in = free_top;
                  order_adapter_in[active_count_ff[ID_W-1:0]] = adapter_ff;
                  order_id_in[active_count_ff[ID_W-1:0]] = free_stack_ff[free_top[ID_W-1:0]];
                  active_count_in = active_count_ff + CNT_W'(1);
                  rsp_slot_id_in  = free_stack_ff[free_top[ID_W-1:0]];
               end
            end
            OP_RETIRE: begin
               if (!retire_found) begin
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  // close the gap: every entry from the hit onward but the last takes its successor
                  for (int i = 0; i < SLOT_CAPACITY - 1; i++) begin
                     if (shift_pos[i]) begin
                        order_adapter_in[i] = order_adapter_ff[i+1];
                        order_id_in[i]      = order_id_ff[i+1];
                     end
                  end
                  active_count_in = active_count_ff - CNT_W'(1);
                  if (free_count_ff < CNT_W'(SLOT_CAPACITY)) begin
                     free_stack_in[free_count_ff[ID_W-1:0]] = rid_ff;
                     free_count_in = free_count_ff + CNT_W'(1);
                  end
               end
            end
            OP_PICK: begin
               if (active_count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_group_adapter_in = best_adapter_ff;
                  rsp_group_size_in    = best_size_ff;
                  for (int j = 0; j < SLOT_CAPACITY; j++) begin
                     if (same_best[j]) begin
                        rsp_group_members_in[order_id_ff[j]] = 1'b1;
                     end
                  end
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end

      if (csr_write_enable) begin
         slot_limit_in   = reload_n;
         active_count_in = '0;
         free_count_in   = reload_n;
         for (int i = 0; i < SLOT_CAPACITY; i++) begin
            free_stack_in[i] = (CNT_W'(i) < reload_n) ? ID_W'(i) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff   <= CNT_W'(SLOT_CAPACITY);
         active_count_ff <= '0;
         free_count_ff   <= CNT_W'(SLOT_CAPACITY);
         for (int i = 0; i < SLOT_CAPACITY; i++) begin
            free_stack_ff[i] <= ID_W'(i);
         end
      end else begin
         slot_limit_ff   <= slot_limit_in;
         active_count_ff <= active_count_in;
         free_count_ff   <= free_count_in;
         free_stack_ff   <= free_stack_in;
      end
   end

   always_ff @(posedge clock) begin
      order_adapter_ff     <= order_adapter_in;
      order_id_ff          <= order_id_in;
      op_ff                <= op_in;
      adapter_ff           <= adapter_in;
      rid_ff               <= rid_in;
      scan_idx_ff          <= scan_idx_in;
      best_size_ff         <= best_size_in;
      best_adapter_ff      <= best_adapter_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_slot_id_ff       <= rsp_slot_id_in;
      rsp_group_adapter_ff <= rsp_group_adapter_in;
      rsp_group_size_ff    <= rsp_group_size_in;
      rsp_group_members_ff <= rsp_group_members_in;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_id       = rsp_slot_id_ff;
   assign rsp_group_adapter = rsp_group_adapter_ff;
   assign rsp_group_size    = rsp_group_size_ff;
   assign rsp_group_members = rsp_group_members_ff;

endmodule

[hw/rtl/lgss_checker.sv]
module lgss_checker
   import lgss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic [ID_W-1:0]          rsp_slot_id,
   input  logic [ADAPTER_BITS-1:0]  rsp_group_adapter,
   input  logic [CNT_W-1:0]         rsp_group_size,
   input  logic [SLOT_CAPACITY-1:0] rsp_group_members
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_slot_id) && $stable(rsp_group_adapter) &&
         $stable(rsp_group_size) && $stable(rsp_group_members))
      else $error("result changed while stalled");

   // one item in flight: no acceptance right after another
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_slot_id == '0) &&
         (rsp_group_adapter == '0) && (rsp_group_size == '0) && (rsp_group_members == '0))
      else $error("error result carries nonzero fields");

   a_group_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |->
         ($countones(rsp_group_members) == int'(rsp_group_size)))
      else $error("group mask does not match group size");

endmodule

bind largest_group_slot_scheduler lgss_checker u_lgss_checker (.*);
